[rtl/core/wsad_pkg.sv]
// ----------------------------------------------------------------------------
// wsad_pkg
// Shared types, register codes and constants of the windowed system-call
// anomaly detector.
// ----------------------------------------------------------------------------
package wsad_pkg;

	// table depth; a power of two, so the slot reduction is a truncation
	localparam int unsigned PROCESS_SLOTS = 1024;
	localparam int unsigned SLOT_IDX_W    = $clog2(PROCESS_SLOTS);

	typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

	localparam logic [8:0] CALL_OPENAT      = 9'd257;
	localparam logic [8:0] CALL_MMAP        = 9'd9;
	localparam logic [8:0] CALL_BRK         = 9'd12;
	localparam logic [8:0] CALL_SETAFFINITY = 9'd203;
	localparam logic [8:0] CALL_SETSCHED    = 9'd144;
	localparam logic [8:0] CALL_SETPRIO     = 9'd141;

	typedef enum logic [2:0] {
		REG_WINDOW_SECONDS   = 3'd0,
		REG_LARGE_MMAP_BYTES = 3'd1,
		REG_CPU_ACCESS_LIMIT = 3'd2,
		REG_LARGE_MMAP_LIMIT = 3'd3,
		REG_HEAP_GROW_LIMIT  = 3'd4,
		REG_SCHEDULER_LIMIT  = 3'd5,
		REG_POINTS_NEEDED    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] window_seconds;
		logic [63:0] large_mmap_bytes;
		logic [7:0]  cpu_access_limit;
		logic [7:0]  large_mmap_limit;
		logic [7:0]  heap_grow_limit;
		logic [7:0]  scheduler_limit;
		logic [2:0]  points_needed;
	} cfg_t;

	typedef struct packed {
		logic [9:0]  process_slot;
		logic [8:0]  syscall_number;
		logic        is_entry;
		logic [31:0] event_seconds;
		logic        path_is_cpu_device;
		logic        mmap_addr_given;
		logic [63:0] mmap_length;
	} item_t;

	typedef struct packed {
		logic [9:0]  slot_out;
		logic [2:0]  suspicious_points;
		logic        newly_flagged;
		logic        flagged;
		logic [31:0] flag_seconds;
	} result_t;

	// one table row per process slot
	typedef struct packed {
		logic [31:0] window_begin;
		logic [7:0]  cpu_open_count;
		logic [7:0]  big_mmap_count;
		logic [7:0]  heap_grow_count;
		logic [7:0]  sched_call_count;
		logic        flagged_mark;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	function automatic slot_idx_t slot_index(input logic [9:0] slot);
		return slot_idx_t'(slot);
	endfunction

endpackage

[rtl/core/wsad_ram.sv]
// ----------------------------------------------------------------------------
// wsad_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module wsad_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/wsad_cfg.sv]
// ----------------------------------------------------------------------------
// wsad_cfg
// Configuration register file: thresholds and window length.
// ----------------------------------------------------------------------------
module wsad_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [63:0]    cfg_data,
	output wsad_pkg::cfg_t cfg
);

	wsad_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_seconds   <= 32'd60;
			cfg_q.large_mmap_bytes <= 64'd67108864;
			cfg_q.cpu_access_limit <= 8'd10;
			cfg_q.large_mmap_limit <= 8'd3;
			cfg_q.heap_grow_limit  <= 8'd3;
			cfg_q.scheduler_limit  <= 8'd10;
			cfg_q.points_needed    <= 3'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wsad_pkg::REG_WINDOW_SECONDS:   cfg_q.window_seconds   <= cfg_data[31:0];
				wsad_pkg::REG_LARGE_MMAP_BYTES: cfg_q.large_mmap_bytes <= cfg_data;
				wsad_pkg::REG_CPU_ACCESS_LIMIT: cfg_q.cpu_access_limit <= cfg_data[7:0];
				wsad_pkg::REG_LARGE_MMAP_LIMIT: cfg_q.large_mmap_limit <= cfg_data[7:0];
				wsad_pkg::REG_HEAP_GROW_LIMIT:  cfg_q.heap_grow_limit  <= cfg_data[7:0];
				wsad_pkg::REG_SCHEDULER_LIMIT:  cfg_q.scheduler_limit  <= cfg_data[7:0];
				wsad_pkg::REG_POINTS_NEEDED:    cfg_q.points_needed    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/core/wsad_update.sv]
// ----------------------------------------------------------------------------
// wsad_update
// Row update: window restart, saturating counts, scoring and first flag.
// ----------------------------------------------------------------------------
module wsad_update (
	input  wsad_pkg::item_t   item,
	input  wsad_pkg::entry_t  cur,
	input  wsad_pkg::cfg_t    cfg,
	output wsad_pkg::entry_t  nxt,
	output wsad_pkg::result_t res
);

	logic        restart;
	logic [31:0] elapsed;
	logic [7:0]  cpu_base, mmap_base, heap_base, sched_base;
	logic        hit_cpu, hit_mmap, hit_heap, hit_sched;
	logic [2:0]  points;
	logic        fresh;

	function automatic logic [7:0] bump(input logic [7:0] c, input logic hit);
		return (hit && c != 8'hFF) ? c + 8'd1 : c;
	endfunction

	always_comb begin
		elapsed = item.event_seconds - cur.window_begin;
		// earlier than window start never restarts
		restart = (cur.window_begin == 32'd0) ||
			(item.event_seconds >= cur.window_begin && elapsed >= cfg.window_seconds);

		cpu_base   = restart ? 8'd0 : cur.cpu_open_count;
		mmap_base  = restart ? 8'd0 : cur.big_mmap_count;
		heap_base  = restart ? 8'd0 : cur.heap_grow_count;
		sched_base = restart ? 8'd0 : cur.sched_call_count;

		hit_cpu   = item.is_entry && item.syscall_number == wsad_pkg::CALL_OPENAT &&
			item.path_is_cpu_device;
		hit_mmap  = item.is_entry && item.syscall_number == wsad_pkg::CALL_MMAP &&
			item.mmap_addr_given && item.mmap_length >= cfg.large_mmap_bytes;
		hit_heap  = item.is_entry && item.syscall_number == wsad_pkg::CALL_BRK;
		hit_sched = item.is_entry && (item.syscall_number == wsad_pkg::CALL_SETAFFINITY ||
			item.syscall_number == wsad_pkg::CALL_SETSCHED ||
			item.syscall_number == wsad_pkg::CALL_SETPRIO);

		nxt.window_begin     = restart ? item.event_seconds : cur.window_begin;
		nxt.cpu_open_count   = bump(cpu_base, hit_cpu);
		nxt.big_mmap_count   = bump(mmap_base, hit_mmap);
		nxt.heap_grow_count  = bump(heap_base, hit_heap);
		nxt.sched_call_count = bump(sched_base, hit_sched);

		points = 3'(nxt.cpu_open_count   >= cfg.cpu_access_limit) +
			3'(nxt.big_mmap_count   >= cfg.large_mmap_limit) +
			3'(nxt.heap_grow_count  >= cfg.heap_grow_limit) +
			3'(nxt.sched_call_count >= cfg.scheduler_limit);

		fresh            = (points >= cfg.points_needed) && !cur.flagged_mark;
		nxt.flagged_mark = cur.flagged_mark | fresh;

		res.slot_out          = item.process_slot;
		res.suspicious_points = points;
		res.newly_flagged     = fresh;
		res.flagged           = nxt.flagged_mark;
		res.flag_seconds      = fresh ? item.event_seconds : 32'd0;
	end

endmodule

[rtl/core/windowed_syscall_anomaly_detector.sv]
// ----------------------------------------------------------------------------
// windowed_syscall_anomaly_detector
// Per-process system-call counting over a time window with threshold scoring.
// ----------------------------------------------------------------------------
// Result: the strobe (done) is registered as ST_RMW ends, after the row read.
// Events: busy holds off a new event until the previous one has left ST_RMW,
//   set by the table read-modify-write (RAM read, then update and write-back).
// Reset: a clearing pass writes all 1024 table rows, one per cycle; busy stays
//   high until the pass is over. Config writes are taken at any time.
// Results cannot be stalled by the receiver.
module windowed_syscall_anomaly_detector (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  wsad_pkg::item_t   item,
	output logic              done,
	output wsad_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW
	} state_t;

	state_t              state_q;
	wsad_pkg::slot_idx_t clr_q;
	wsad_pkg::item_t     item_s1;
	wsad_pkg::cfg_t      cfg;
	wsad_pkg::entry_t    cur_entry;
	wsad_pkg::entry_t    nxt_entry;
	wsad_pkg::result_t   upd_res;

	logic                          ram_we;
	wsad_pkg::slot_idx_t           ram_waddr;
	logic [wsad_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [wsad_pkg::ENTRY_W-1:0]  ram_rdata;
	logic                          accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		cur_entry = wsad_pkg::entry_t'(ram_rdata);
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_RMW: begin
				ram_we    = 1'b1;
				ram_waddr = wsad_pkg::slot_index(item_s1.process_slot);
				ram_wdata = nxt_entry;
			end
			default: ;
		endcase
	end

	wsad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wsad_ram #(
		.WIDTH (wsad_pkg::ENTRY_W),
		.DEPTH (wsad_pkg::PROCESS_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (wsad_pkg::slot_index(item.process_slot)),
		.rdata (ram_rdata)
	);

	wsad_update u_update (
		.item (item_s1),
		.cur  (cur_entry),
		.cfg  (cfg),
		.nxt  (nxt_entry),
		.res  (upd_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == wsad_pkg::slot_idx_t'(wsad_pkg::PROCESS_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RMW;
					end
				end
				ST_RMW: begin
					// write-back lands this edge, so the next read sees it
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (state_q == ST_RMW) begin
			result <= upd_res;
		end
	end

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("accepted beat did not produce a result");

	a_result_from_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RMW))
		else $error("result strobe without a table update");

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_new_flag_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.newly_flagged) |-> result.flagged)
		else $error("new flag reported without flagged mark");

endmodule

[test/windowed_syscall_anomaly_detector_tb.sv]
// ----------------------------------------------------------------------------
// windowed_syscall_anomaly_detector_tb
// Drives system-call events through the detector and checks every result
// against a cycle-free score predictor kept in step with the configuration.
// A directed burst covers the corner cases; several configuration phases
// follow with random event streams and random sender gaps.
// ----------------------------------------------------------------------------
module windowed_syscall_anomaly_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	wsad_pkg::item_t   item = '0;
	logic              done;
	wsad_pkg::result_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index = '0;
	logic [63:0]       cfg_data = '0;

	windowed_syscall_anomaly_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the configuration
	logic [31:0] win_len   = 32'd60;
	logic [63:0] big_len   = 64'd67108864;
	logic [7:0]  lim_cpu   = 8'd10;
	logic [7:0]  lim_mmap  = 8'd3;
	logic [7:0]  lim_heap  = 8'd3;
	logic [7:0]  lim_sched = 8'd10;
	logic [2:0]  pts_need  = 3'd3;

	// predictor copy of the per-process table
	logic [31:0] win_start  [wsad_pkg::PROCESS_SLOTS];
	logic [7:0]  cpu_opens  [wsad_pkg::PROCESS_SLOTS];
	logic [7:0]  big_mmaps  [wsad_pkg::PROCESS_SLOTS];
	logic [7:0]  heap_grows [wsad_pkg::PROCESS_SLOTS];
	logic [7:0]  sched_hits [wsad_pkg::PROCESS_SLOTS];
	logic        was_flagged[wsad_pkg::PROCESS_SLOTS];

	wsad_pkg::item_t   event_queue[$];
	wsad_pkg::result_t predicted_scores[$];
	int unsigned       events_left = 0;
	int unsigned       gap_cap = 0;
	int unsigned       gap_left = 0;
	int unsigned       bad_results = 0;

	function automatic logic [7:0] sat_inc(input logic [7:0] c);
		return (c == 8'hFF) ? c : c + 8'd1;
	endfunction

	function automatic wsad_pkg::result_t score_event(input wsad_pkg::item_t ev);
		wsad_pkg::slot_idx_t s;
		logic [2:0]          pts;
		logic                fresh;
		wsad_pkg::result_t   r;
		s = wsad_pkg::slot_idx_t'(ev.process_slot % wsad_pkg::PROCESS_SLOTS);
		if (win_start[s] == 32'd0 || (ev.event_seconds >= win_start[s] &&
				ev.event_seconds - win_start[s] >= win_len)) begin
			win_start[s]  = ev.event_seconds;
			cpu_opens[s]  = 8'd0;
			big_mmaps[s]  = 8'd0;
			heap_grows[s] = 8'd0;
			sched_hits[s] = 8'd0;
		end
		if (ev.is_entry) begin
			if (ev.syscall_number == wsad_pkg::CALL_OPENAT && ev.path_is_cpu_device)
				cpu_opens[s] = sat_inc(cpu_opens[s]);
			if (ev.syscall_number == wsad_pkg::CALL_MMAP && ev.mmap_addr_given &&
					ev.mmap_length >= big_len)
				big_mmaps[s] = sat_inc(big_mmaps[s]);
			if (ev.syscall_number == wsad_pkg::CALL_BRK)
				heap_grows[s] = sat_inc(heap_grows[s]);
			if (ev.syscall_number == wsad_pkg::CALL_SETAFFINITY ||
					ev.syscall_number == wsad_pkg::CALL_SETSCHED ||
					ev.syscall_number == wsad_pkg::CALL_SETPRIO)
				sched_hits[s] = sat_inc(sched_hits[s]);
		end
		pts = 3'd0;
		if (cpu_opens[s] >= lim_cpu) pts = pts + 3'd1;
		if (big_mmaps[s] >= lim_mmap) pts = pts + 3'd1;
		if (heap_grows[s] >= lim_heap) pts = pts + 3'd1;
		if (sched_hits[s] >= lim_sched) pts = pts + 3'd1;
		fresh = 1'b0;
		if (pts >= pts_need && !was_flagged[s]) begin
			was_flagged[s] = 1'b1;
			fresh = 1'b1;
		end
		r.slot_out          = ev.process_slot;
		r.suspicious_points = pts;
		r.newly_flagged     = fresh;
		r.flagged           = was_flagged[s];
		r.flag_seconds      = fresh ? ev.event_seconds : 32'd0;
		return r;
	endfunction

	// driver: one beat per start/!busy edge, random gap after each beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predicted_scores = {predicted_scores, score_event(item)};
				events_left--;
			end
			if (start && busy) begin
				// beat still pending
			end else if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (event_queue.size() != 0) begin
				item <= event_queue.pop_front();
				start <= 1'b1;
				gap_left = $urandom_range(gap_cap, 0);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: results cannot be stalled, so every strobe is one beat
	always @(posedge clk) begin
		wsad_pkg::result_t want;
		if (arst_n && done) begin
			if (predicted_scores.size() == 0) begin
				if (bad_results < 10)
					$display("unexpected result: slot %0d pts %0d", result.slot_out,
						result.suspicious_points);
				bad_results++;
			end else begin
				want = predicted_scores.pop_front();
				if (result.slot_out !== want.slot_out ||
						result.suspicious_points !== want.suspicious_points ||
						result.newly_flagged !== want.newly_flagged ||
						result.flagged !== want.flagged ||
						result.flag_seconds !== want.flag_seconds) begin
					if (bad_results < 10) begin
						$display("mismatch: exp slot %0d pts %0d new %0b flag %0b sec %0d",
							want.slot_out, want.suspicious_points, want.newly_flagged,
							want.flagged, want.flag_seconds);
						$display("          got slot %0d pts %0d new %0b flag %0b sec %0d",
							result.slot_out, result.suspicious_points,
							result.newly_flagged, result.flagged, result.flag_seconds);
					end
					bad_results++;
				end
			end
		end
	end

	task automatic add_event(input logic [9:0] slot, input logic [8:0] call, input logic entry,
			input logic [31:0] secs, input logic cpu, input logic addr, input logic [63:0] len);
		wsad_pkg::item_t ev;
		ev.process_slot       = slot;
		ev.syscall_number     = call;
		ev.is_entry           = entry;
		ev.event_seconds      = secs;
		ev.path_is_cpu_device = cpu;
		ev.mmap_addr_given    = addr;
		ev.mmap_length        = len;
		event_queue = {event_queue, ev};
		events_left++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			wsad_pkg::REG_WINDOW_SECONDS:   win_len   = data[31:0];
			wsad_pkg::REG_LARGE_MMAP_BYTES: big_len   = data;
			wsad_pkg::REG_CPU_ACCESS_LIMIT: lim_cpu   = data[7:0];
			wsad_pkg::REG_LARGE_MMAP_LIMIT: lim_mmap  = data[7:0];
			wsad_pkg::REG_HEAP_GROW_LIMIT:  lim_heap  = data[7:0];
			wsad_pkg::REG_SCHEDULER_LIMIT:  lim_sched = data[7:0];
			wsad_pkg::REG_POINTS_NEEDED:    pts_need  = data[2:0];
			default: ;
		endcase
	endtask

	// upper bits of the narrow registers carry junk; the block keeps the low bits
	task automatic set_config(input logic [31:0] w, input logic [63:0] bytes,
			input logic [7:0] cpu, input logic [7:0] mm, input logic [7:0] heap,
			input logic [7:0] sched, input logic [2:0] pts);
		write_reg(wsad_pkg::REG_WINDOW_SECONDS, {32'($urandom), w});
		write_reg(wsad_pkg::REG_LARGE_MMAP_BYTES, bytes);
		write_reg(wsad_pkg::REG_CPU_ACCESS_LIMIT, {24'($urandom), 32'($urandom), cpu});
		write_reg(wsad_pkg::REG_LARGE_MMAP_LIMIT, {24'($urandom), 32'($urandom), mm});
		write_reg(wsad_pkg::REG_HEAP_GROW_LIMIT, {24'($urandom), 32'($urandom), heap});
		write_reg(wsad_pkg::REG_SCHEDULER_LIMIT, {24'($urandom), 32'($urandom), sched});
		write_reg(wsad_pkg::REG_POINTS_NEEDED, {29'($urandom), 32'($urandom), pts});
	endtask

	task automatic settle_block();
		while (events_left != 0 || predicted_scores.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly a few busy processes doing the counted calls, some noise around them
	task automatic add_random_events(input int n);
		logic [9:0]  hot [4];
		logic [31:0] clock_s;
		logic [31:0] secs;
		logic [8:0]  call;
		logic [63:0] len;
		logic [9:0]  slot;
		int          pick;
		foreach (hot[k]) hot[k] = 10'($urandom_range(1023, 0));
		clock_s = $urandom_range(1, 0) ? 32'($urandom_range(1000, 1)) : 32'($urandom);
		repeat (n) begin
			slot = ($urandom_range(99, 0) < 80) ? hot[$urandom_range(3, 0)] :
				10'($urandom_range(1023, 0));
			pick = $urandom_range(9, 0);
			case (pick)
				0, 8:    call = wsad_pkg::CALL_OPENAT;
				1, 9:    call = wsad_pkg::CALL_MMAP;
				2:       call = wsad_pkg::CALL_BRK;
				3:       call = wsad_pkg::CALL_SETAFFINITY;
				4:       call = wsad_pkg::CALL_SETSCHED;
				5:       call = wsad_pkg::CALL_SETPRIO;
				default: call = 9'($urandom_range(511, 0));
			endcase
			pick = $urandom_range(19, 0);
			case (pick)
				0:       secs = 32'd0;
				1:       secs = 32'hFFFF_FFFF;
				2:       secs = clock_s - 32'($urandom_range(50, 1));
				3: begin
					clock_s = clock_s + 32'($urandom_range(1000, 50));
					secs = clock_s;
				end
				default: begin
					clock_s = clock_s + 32'($urandom_range(3, 0));
					secs = clock_s;
				end
			endcase
			pick = $urandom_range(5, 0);
			case (pick)
				0:       len = big_len - 64'd1;
				1:       len = big_len;
				2:       len = big_len + 64'd1;
				3:       len = {32'($urandom), 32'($urandom)};
				4:       len = '0;
				default: len = '1;
			endcase
			add_event(slot, call, $urandom_range(9, 0) != 0, secs, $urandom_range(3, 0) != 0,
				$urandom_range(4, 0) != 0, len);
		end
	endtask

	initial begin
		for (int k = 0; k < wsad_pkg::PROCESS_SLOTS; k++) begin
			win_start[k]   = '0;
			cpu_opens[k]   = '0;
			big_mmaps[k]   = '0;
			heap_grows[k]  = '0;
			sched_hits[k]  = '0;
			was_flagged[k] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// table clearing pass after reset
		do @(posedge clk); while (busy);

		// directed burst at reset configuration
		gap_cap = 16;
		add_event(10'd0, wsad_pkg::CALL_OPENAT, 1'b1, 32'd0, 1'b1, 1'b0, 64'd0);
		add_event(10'd0, wsad_pkg::CALL_BRK, 1'b1, 32'd0, 1'b0, 1'b0, 64'd0);
		add_event(10'd0, wsad_pkg::CALL_BRK, 1'b1, 32'd100, 1'b0, 1'b0, 64'd0);
		add_event(10'd0, wsad_pkg::CALL_BRK, 1'b1, 32'd50, 1'b0, 1'b0, 64'd0);
		add_event(10'd0, wsad_pkg::CALL_BRK, 1'b1, 32'd159, 1'b0, 1'b0, 64'd0);
		add_event(10'd0, wsad_pkg::CALL_MMAP, 1'b1, 32'd120, 1'b0, 1'b1, 64'd67108864);
		add_event(10'd0, wsad_pkg::CALL_MMAP, 1'b1, 32'd120, 1'b0, 1'b1, 64'd67108863);
		add_event(10'd0, wsad_pkg::CALL_MMAP, 1'b1, 32'd121, 1'b0, 1'b0, '1);
		add_event(10'd0, wsad_pkg::CALL_MMAP, 1'b1, 32'd121, 1'b0, 1'b1, '1);
		add_event(10'd0, wsad_pkg::CALL_MMAP, 1'b0, 32'd122, 1'b0, 1'b1, '1);
		add_event(10'd0, wsad_pkg::CALL_MMAP, 1'b1, 32'd122, 1'b0, 1'b1, '1);
		add_event(10'd0, wsad_pkg::CALL_BRK, 1'b1, 32'd160, 1'b0, 1'b0, 64'd0);
		add_event(10'd1023, 9'd511, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, '1);
		add_event(10'd1023, wsad_pkg::CALL_SETAFFINITY, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0,
			64'd0);
		add_event(10'd1023, wsad_pkg::CALL_SETSCHED, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 64'd0);
		add_event(10'd1023, wsad_pkg::CALL_SETPRIO, 1'b1, 32'hFFFF_FFFE, 1'b0, 1'b0, 64'd0);
		add_event(10'd1023, wsad_pkg::CALL_OPENAT, 1'b1, 32'd5, 1'b0, 1'b0, 64'd0);
		add_event(10'd1023, wsad_pkg::CALL_OPENAT, 1'b1, 32'd5, 1'b1, 1'b0, 64'd0);
		add_event(10'd1023, wsad_pkg::CALL_OPENAT, 1'b0, 32'd6, 1'b1, 1'b0, 64'd0);
		add_event(10'd512, 9'd0, 1'b0, 32'd7, 1'b0, 1'b0, 64'd0);
		settle_block();

		// low extremes: zero window, every limit met at once, unknown register index
		write_reg(REG_UNUSED, {32'($urandom), 32'($urandom)});
		set_config(32'd0, 64'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
		gap_cap = 3;
		add_random_events(30);
		settle_block();

		// high extremes: nothing is ever flagged
		set_config(32'hFFFF_FFFF, '1, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7);
		gap_cap = 16;
		add_random_events(30);
		settle_block();

		// heap counter driven into saturation, back to back
		set_config(32'hFFFF_FFFF, 64'd0, 8'd255, 8'd255, 8'd255, 8'd255, 3'd1);
		gap_cap = 0;
		for (int k = 0; k < 270; k++)
			add_event(10'd300, wsad_pkg::CALL_BRK, 1'b1, 32'(1000 + k), 1'b0, 1'b0, 64'd0);
		settle_block();

		for (int p = 0; p < 6; p++) begin
			set_config(($urandom_range(3, 0) != 0) ? 32'($urandom_range(30, 1)) : 32'($urandom),
				($urandom_range(1, 0) != 0) ? 64'($urandom_range(1 << 20, 0)) :
					{32'($urandom), 32'($urandom)},
				8'($urandom_range(6, 0)), 8'($urandom_range(6, 0)), 8'($urandom_range(6, 0)),
				8'($urandom_range(6, 0)),
				($urandom_range(4, 0) != 0) ? 3'($urandom_range(4, 0)) : 3'($urandom_range(7, 5)));
			case (p % 3)
				0:       gap_cap = 0;
				1:       gap_cap = 16;
				default: gap_cap = 4;
			endcase
			add_random_events(17);
			settle_block();
		end

		repeat (8) @(posedge clk);
		if (bad_results == 0 && predicted_scores.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[windowed_syscall_anomaly_detector.f]
rtl/core/wsad_pkg.sv
rtl/core/wsad_ram.sv
rtl/core/wsad_cfg.sv
rtl/core/wsad_update.sv
rtl/core/windowed_syscall_anomaly_detector.sv
test/windowed_syscall_anomaly_detector_tb.sv
